// ----- rtl/ellipse_vertex_tracker_top_macros.svh -----
// ----------------------------------------------------------------------------
// Ellipse vertex tracker assertion macros
// Concurrent assertion shorthands shared by the tracker RTL.
// ----------------------------------------------------------------------------
`ifndef ELLIPSE_VERTEX_TRACKER_TOP_MACROS_SVH
`define ELLIPSE_VERTEX_TRACKER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define EVT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define EVT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/evt_pkg.sv -----
// ----------------------------------------------------------------------------
// Ellipse vertex tracker package
// Widths, fixed-point constants, sequencer types and helper functions.
// ----------------------------------------------------------------------------
package evt_pkg;

    localparam int TRIG_ITERATIONS_DEF = 18;

    localparam int COORD_W = 32;
    localparam int TURN_W  = 20;
    localparam int AXIS_W  = 31;
    localparam int AREA_W  = 48;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SEMI_MAJOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEMI_MINOR = 2'd1;

    localparam logic [AXIS_W-1:0] SEMI_MAJOR_RST = 31'd196608;
    localparam logic [AXIS_W-1:0] SEMI_MINOR_RST = 31'd131072;

    // Heading in Q16 radians, kept in [0, 2*pi).
    localparam int HEAD_W = 19;
    localparam int HSUM_W = 21;
    localparam logic signed [HSUM_W-1:0] TWO_PI_Q16 = 21'sd411775;

    // CORDIC datapath in Q30.
    localparam int CORDIC_W = 33;
    localparam int FOLD_W   = 35;
    localparam logic signed [FOLD_W-1:0] HALF_PI_Q30    = 35'sd1686629713;
    localparam logic signed [FOLD_W-1:0] PI_Q30         = 35'sd3373259426;
    localparam logic signed [FOLD_W-1:0] THREE_HALF_PI  = 35'sd5059889139;
    localparam logic signed [FOLD_W-1:0] TWO_PI_Q30     = 35'sd6746518852;
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN  = 33'sd652032874;

    localparam logic [31:0] AREA_CONST_Q30 = 32'd3373267314;

    localparam int MUL_W  = 33;
    localparam int PROD_W = 64;
    localparam int TERM_W = 33;

    // Last step of the scaling phase.
    localparam int SCALE_LAST = 5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRAP,
        ST_FOLD,
        ST_CORDIC,
        ST_SCALE,
        ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_AB,
        MUL_AREA_HI,
        MUL_AREA_LO,
        MUL_AX,
        MUL_AY,
        MUL_BX,
        MUL_BY
    } t_mul_op;

    typedef enum logic [2:0] {
        CAP_NONE,
        CAP_AB_LO,
        CAP_AREA_HI,
        CAP_AREA,
        CAP_AX,
        CAP_AY,
        CAP_BX,
        CAP_BY
    } t_cap_op;

    typedef struct packed {
        logic    in_ready;
        logic    fold_load;
        logic    cordic_en;
        logic    trig_neg;
        logic    out_load;
        t_mul_op mul_op;
        t_cap_op cap_op;
    } t_ctrl;

    // Arctangent of 2^-i in Q30, truncated.
    function automatic logic [29:0] atan_q30(input logic [4:0] idx);
        logic [29:0] v;
        case (idx)
            5'd0:    v = 30'h3243F6A8;
            5'd1:    v = 30'h1DAC6705;
            5'd2:    v = 30'h0FADBAFC;
            5'd3:    v = 30'h07F56EA6;
            5'd4:    v = 30'h03FEAB76;
            5'd5:    v = 30'h01FFD55B;
            5'd6:    v = 30'h00FFFAAA;
            5'd7:    v = 30'h007FFF55;
            5'd8:    v = 30'h003FFFEA;
            5'd9:    v = 30'h001FFFFD;
            5'd10:   v = 30'h000FFFFF;
            5'd11:   v = 30'h0007FFFF;
            5'd12:   v = 30'h0003FFFF;
            5'd13:   v = 30'h0001FFFF;
            5'd14:   v = 30'h0000FFFF;
            5'd15:   v = 30'h00007FFF;
            5'd16:   v = 30'h00003FFF;
            5'd17:   v = 30'h00001FFF;
            5'd18:   v = 30'h00000FFF;
            5'd19:   v = 30'h000007FF;
            5'd20:   v = 30'h000003FF;
            5'd21:   v = 30'h000001FF;
            5'd22:   v = 30'h000000FF;
            5'd23:   v = 30'h0000007F;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Saturate a 34-bit signed value to 32 bits.
    function automatic logic signed [COORD_W-1:0] sat32(input logic signed [33:0] v);
        logic signed [COORD_W-1:0] r;
        if (v > 34'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -34'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

endpackage

// ----- rtl/evt_in_if.sv -----
// ----------------------------------------------------------------------------
// Ellipse vertex tracker input channel
// Valid/ready channel carrying one centre shift and one turn.
// ----------------------------------------------------------------------------
interface evt_in_if import evt_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] shift_x;
    logic signed [COORD_W-1:0] shift_y;
    logic signed [TURN_W-1:0]  turn;

    modport source (output valid, output shift_x, output shift_y, output turn, input ready);
    modport sink   (input valid, input shift_x, input shift_y, input turn, output ready);
endinterface

// ----- rtl/evt_out_if.sv -----
// ----------------------------------------------------------------------------
// Ellipse vertex tracker result channel
// Valid/ready channel carrying the four vertices and the area.
// ----------------------------------------------------------------------------
interface evt_out_if import evt_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] right_x;
    logic signed [COORD_W-1:0] right_y;
    logic signed [COORD_W-1:0] left_x;
    logic signed [COORD_W-1:0] left_y;
    logic signed [COORD_W-1:0] top_x;
    logic signed [COORD_W-1:0] top_y;
    logic signed [COORD_W-1:0] bottom_x;
    logic signed [COORD_W-1:0] bottom_y;
    logic        [AREA_W-1:0]  area_out;

    modport source (
        output valid, output right_x, output right_y, output left_x, output left_y,
        output top_x, output top_y, output bottom_x, output bottom_y, output area_out,
        input ready
    );
    modport sink (
        input valid, input right_x, input right_y, input left_x, input left_y,
        input top_x, input top_y, input bottom_x, input bottom_y, input area_out,
        output ready
    );
endinterface

// ----- rtl/evt_cfg_if.sv -----
// ----------------------------------------------------------------------------
// Ellipse vertex tracker configuration channel
// Valid/ready register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface evt_cfg_if import evt_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/ellipse_vertex_tracker_top.sv -----
// ----------------------------------------------------------------------------
// Ellipse vertex tracker
// Each transfer moves the centre and turns the ellipse, and the block
// returns the four vertices and the area. One item is in flight at a time:
// after an input transfer the block wraps the heading, folds it, runs
// TRIG_ITERATIONS CORDIC steps, scales through the single shared 33x33
// multiplier and loads the result register once the previous result has
// been taken; the block is ready for the next input in the cycle after
// the result register is loaded. The three area products share the
// multiplier while the CORDIC runs. Semi-axes are written on the
// configuration channel, which is ready whenever reset is released;
// neither channel is ready during reset.
// ----------------------------------------------------------------------------
`include "ellipse_vertex_tracker_top_macros.svh"

module ellipse_vertex_tracker_top import evt_pkg::*; #(
    parameter int TRIG_ITERATIONS = TRIG_ITERATIONS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    evt_in_if.sink           i_in,
    evt_out_if.source        o_out,
    evt_cfg_if.sink          i_cfg
);

    localparam int STEP_W = $clog2(TRIG_ITERATIONS);

    t_state r_state, n_state;
    t_ctrl  ctrl;

    logic [STEP_W-1:0] r_step, n_step;

    logic [AXIS_W-1:0]         r_major;
    logic [AXIS_W-1:0]         r_minor;
    logic signed [COORD_W-1:0] r_center_x;
    logic signed [COORD_W-1:0] r_center_y;
    logic [HEAD_W-1:0]         r_heading;
    logic                      r_out_valid;

    logic signed [HSUM_W-1:0]   r_hsum;
    logic signed [CORDIC_W-1:0] r_x;
    logic signed [CORDIC_W-1:0] r_y;
    logic signed [CORDIC_W-1:0] r_z;
    logic                       r_neg;
    logic signed [PROD_W-1:0]   r_prod;
    logic [31:0]                r_ab_lo;
    logic [61:0]                r_area_hi;
    logic [AREA_W-1:0]          r_area;
    logic signed [TERM_W-1:0]   r_ax;
    logic signed [TERM_W-1:0]   r_ay;
    logic signed [TERM_W-1:0]   r_bx;
    logic signed [TERM_W-1:0]   r_by;

    logic signed [COORD_W-1:0] r_right_x;
    logic signed [COORD_W-1:0] r_right_y;
    logic signed [COORD_W-1:0] r_left_x;
    logic signed [COORD_W-1:0] r_left_y;
    logic signed [COORD_W-1:0] r_top_x;
    logic signed [COORD_W-1:0] r_top_y;
    logic signed [COORD_W-1:0] r_bottom_x;
    logic signed [COORD_W-1:0] r_bottom_y;
    logic [AREA_W-1:0]         r_area_out;

    logic in_fire;
    logic out_fire;
    logic wrap_done;

    logic signed [FOLD_W-1:0]   fold_z;
    logic signed [FOLD_W-1:0]   fold_res;
    logic                       fold_neg;
    logic signed [CORDIC_W-1:0] dx;
    logic signed [CORDIC_W-1:0] dy;
    logic signed [CORDIC_W-1:0] atan_v;

    logic signed [MUL_W-1:0]    mul_a;
    logic signed [MUL_W-1:0]    mul_b;
    logic signed [2*MUL_W-1:0]  mul_full;
    logic signed [PROD_W-1:0]   term_sum;
    logic [62:0]                area_sum;

    assign in_fire   = i_in.valid && ctrl.in_ready;
    assign out_fire  = r_out_valid && o_out.ready;
    assign wrap_done = !r_hsum[HSUM_W-1] && (r_hsum < TWO_PI_Q16);

    assign i_in.ready  = ctrl.in_ready;
    assign i_cfg.ready = i_rst_n;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) n_state = ST_WRAP;
            end
            ST_WRAP: begin
                if (wrap_done) n_state = ST_FOLD;
            end
            ST_FOLD: begin
                n_state = ST_CORDIC;
            end
            ST_CORDIC: begin
                if (r_step == STEP_W'(TRIG_ITERATIONS - 1)) n_state = ST_SCALE;
            end
            ST_SCALE: begin
                if (r_step == STEP_W'(SCALE_LAST)) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (ctrl.out_load) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        ctrl = '{in_ready: 1'b0, fold_load: 1'b0, cordic_en: 1'b0, trig_neg: 1'b0,
                 out_load: 1'b0, mul_op: MUL_NONE, cap_op: CAP_NONE};
        unique case (r_state)
            ST_IDLE:   ctrl.in_ready = i_rst_n;
            ST_WRAP:   ;
            ST_FOLD:   ctrl.fold_load = 1'b1;
            ST_CORDIC: begin
                ctrl.cordic_en = 1'b1;
                // The area products use the multiplier while it is otherwise idle.
                case (r_step)
                    STEP_W'(0): ctrl.mul_op = MUL_AB;
                    STEP_W'(1): begin
                        ctrl.mul_op = MUL_AREA_HI;
                        ctrl.cap_op = CAP_AB_LO;
                    end
                    STEP_W'(2): begin
                        ctrl.mul_op = MUL_AREA_LO;
                        ctrl.cap_op = CAP_AREA_HI;
                    end
                    STEP_W'(3): ctrl.cap_op = CAP_AREA;
                    default:    ;
                endcase
            end
            ST_SCALE: begin
                case (r_step)
                    STEP_W'(0): ctrl.trig_neg = 1'b1;
                    STEP_W'(1): ctrl.mul_op = MUL_AX;
                    STEP_W'(2): begin
                        ctrl.mul_op = MUL_AY;
                        ctrl.cap_op = CAP_AX;
                    end
                    STEP_W'(3): begin
                        ctrl.mul_op = MUL_BX;
                        ctrl.cap_op = CAP_AY;
                    end
                    STEP_W'(4): begin
                        ctrl.mul_op = MUL_BY;
                        ctrl.cap_op = CAP_BX;
                    end
                    STEP_W'(5): ctrl.cap_op = CAP_BY;
                    default:    ;
                endcase
            end
            ST_DONE:   ctrl.out_load = !r_out_valid || o_out.ready;
            default:   ;
        endcase
    end

    always_comb begin
        n_step = r_step;
        if (r_state == ST_FOLD) begin
            n_step = '0;
        end else if (r_state == ST_CORDIC) begin
            n_step = (r_step == STEP_W'(TRIG_ITERATIONS - 1)) ? '0 : r_step + 1'b1;
        end else if (r_state == ST_SCALE) begin
            n_step = r_step + 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Datapath
    // ------------------------------------------------------------------
    always_comb begin
        fold_z   = $signed({2'b00, r_hsum[HEAD_W-1:0], 14'b0});
        fold_res = fold_z;
        fold_neg = 1'b0;
        if (fold_z > HALF_PI_Q30) begin
            if (fold_z < THREE_HALF_PI) begin
                fold_res = fold_z - PI_Q30;
                fold_neg = 1'b1;
            end else begin
                fold_res = fold_z - TWO_PI_Q30;
            end
        end
    end

    assign dx     = r_y >>> r_step;
    assign dy     = r_x >>> r_step;
    assign atan_v = $signed(CORDIC_W'(atan_q30(5'(r_step))));

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (ctrl.mul_op)
            MUL_AB: begin
                mul_a = $signed(MUL_W'(r_major));
                mul_b = $signed(MUL_W'(r_minor));
            end
            MUL_AREA_HI: begin
                mul_a = $signed(MUL_W'(r_prod[63:32]));
                mul_b = $signed(MUL_W'(AREA_CONST_Q30));
            end
            MUL_AREA_LO: begin
                mul_a = $signed(MUL_W'(r_ab_lo));
                mul_b = $signed(MUL_W'(AREA_CONST_Q30));
            end
            MUL_AX: begin
                mul_a = $signed(MUL_W'(r_major));
                mul_b = r_x;
            end
            MUL_AY: begin
                mul_a = $signed(MUL_W'(r_major));
                mul_b = r_y;
            end
            MUL_BX: begin
                mul_a = $signed(MUL_W'(r_minor));
                mul_b = r_y;
            end
            MUL_BY: begin
                mul_a = $signed(MUL_W'(r_minor));
                mul_b = r_x;
            end
            default: ;
        endcase
    end

    assign mul_full = mul_a * mul_b;
    // Round half up, then floor by 2^30.
    assign term_sum = r_prod + 64'sd536870912;
    assign area_sum = {1'b0, r_area_hi} + 63'(r_prod[63:32]) + 63'd8192;

    // Control and architectural state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_major     <= SEMI_MAJOR_RST;
            r_minor     <= SEMI_MINOR_RST;
            r_center_x  <= '0;
            r_center_y  <= '0;
            r_heading   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    CFG_SEMI_MAJOR: r_major <= i_cfg.data[AXIS_W-1:0];
                    CFG_SEMI_MINOR: r_minor <= i_cfg.data[AXIS_W-1:0];
                    default:        ;
                endcase
            end
            if (in_fire) begin
                r_center_x <= sat32(34'(r_center_x) + 34'(i_in.shift_x));
                r_center_y <= sat32(34'(r_center_y) + 34'(i_in.shift_y));
            end
            if (ctrl.fold_load) begin
                r_heading <= r_hsum[HEAD_W-1:0];
            end
            if (ctrl.out_load) begin
                r_out_valid <= 1'b1;
            end else if (out_fire) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_full[PROD_W-1:0];

        if (in_fire) begin
            r_hsum <= $signed(HSUM_W'(r_heading)) + HSUM_W'(i_in.turn);
        end else if (r_state == ST_WRAP) begin
            // At most two corrections are ever needed.
            if (r_hsum[HSUM_W-1]) begin
                r_hsum <= r_hsum + TWO_PI_Q16;
            end else if (r_hsum >= TWO_PI_Q16) begin
                r_hsum <= r_hsum - TWO_PI_Q16;
            end
        end

        if (ctrl.fold_load) begin
            r_x   <= CORDIC_GAIN;
            r_y   <= '0;
            r_z   <= fold_res[CORDIC_W-1:0];
            r_neg <= fold_neg;
        end else if (ctrl.cordic_en) begin
            if (!r_z[CORDIC_W-1]) begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - atan_v;
            end else begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + atan_v;
            end
        end else if (ctrl.trig_neg && r_neg) begin
            r_x <= -r_x;
            r_y <= -r_y;
        end

        case (ctrl.cap_op)
            CAP_AB_LO:   r_ab_lo   <= r_prod[31:0];
            CAP_AREA_HI: r_area_hi <= r_prod[61:0];
            CAP_AREA:    r_area    <= area_sum[61:14];
            CAP_AX:      r_ax      <= term_sum[62:30];
            CAP_AY:      r_ay      <= term_sum[62:30];
            CAP_BX:      r_bx      <= term_sum[62:30];
            CAP_BY:      r_by      <= term_sum[62:30];
            default:     ;
        endcase

        if (ctrl.out_load) begin
            r_right_x  <= sat32(34'(r_center_x) + 34'(r_ax));
            r_right_y  <= sat32(34'(r_center_y) + 34'(r_ay));
            r_left_x   <= sat32(34'(r_center_x) - 34'(r_ax));
            r_left_y   <= sat32(34'(r_center_y) - 34'(r_ay));
            r_top_x    <= sat32(34'(r_center_x) - 34'(r_bx));
            r_top_y    <= sat32(34'(r_center_y) + 34'(r_by));
            r_bottom_x <= sat32(34'(r_center_x) + 34'(r_bx));
            r_bottom_y <= sat32(34'(r_center_y) - 34'(r_by));
            r_area_out <= r_area;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.right_x  = r_right_x;
    assign o_out.right_y  = r_right_y;
    assign o_out.left_x   = r_left_x;
    assign o_out.left_y   = r_left_y;
    assign o_out.top_x    = r_top_x;
    assign o_out.top_y    = r_top_y;
    assign o_out.bottom_x = r_bottom_x;
    assign o_out.bottom_y = r_bottom_y;
    assign o_out.area_out = r_area_out;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `EVT_ASSERT_NOW(a_heading_range, i_clk, i_rst_n, r_state == ST_IDLE,
        r_heading < HEAD_W'(TWO_PI_Q16), "heading left the range [0, 2*pi)")
    `EVT_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, in_fire,
        r_state == ST_WRAP && !i_in.ready, "input transfer did not start the sequencer")
    `EVT_ASSERT_NOW(a_cordic_step, i_clk, i_rst_n, r_state == ST_CORDIC,
        int'(r_step) < TRIG_ITERATIONS, "CORDIC step counter ran past the last step")
    `EVT_ASSERT_NEXT(a_load_valid, i_clk, i_rst_n, ctrl.out_load,
        r_out_valid && r_state == ST_IDLE, "result load did not raise valid")

endmodule

// ----- tb/ellipse_vertex_tracker_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ellipse vertex tracker testbench
// Drives centre shifts and turns into the tracker under random idling on
// both channels, predicts every vertex set and area from a cycle-free model
// of the centre, heading and CORDIC, and compares each result transfer field
// by field. Directed items cover the fold and wrap boundaries, saturation and
// extreme axes; random phases then run with fresh semi-axis settings.
// ----------------------------------------------------------------------------
module ellipse_vertex_tracker_top_test import evt_pkg::*; ();

    localparam int TRIG_STEPS      = 18;
    localparam int RANDOM_PHASES   = 7;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int HOLD_PHASE      = 3;
    localparam int LONG_HOLD       = 400;
    localparam int DRAIN_CYCLES    = 40;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    localparam longint FULL_TURN_Q16    = 411775;
    localparam longint HALF_TURN_Q30    = 64'sd3373259426;
    localparam longint QUARTER_TURN_Q30 = 64'sd1686629713;
    localparam longint TRIG_GAIN_Q30    = 64'sd652032874;
    localparam bit [63:0] AREA_PI_Q30   = 64'd3373267314;
    localparam longint COORD_MAX        = 64'sd2147483647;
    localparam longint COORD_MIN        = -64'sd2147483648;

    localparam logic signed [COORD_W-1:0] SHIFT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] SHIFT_MIN = 32'sh8000_0000;
    localparam logic signed [TURN_W-1:0]  TURN_MAX  = 20'sh7FFFF;
    localparam logic signed [TURN_W-1:0]  TURN_MIN  = 20'sh80000;

    typedef struct {
        logic signed [COORD_W-1:0] shift_x;
        logic signed [COORD_W-1:0] shift_y;
        logic signed [TURN_W-1:0]  turn;
    } t_motion;

    typedef struct {
        logic signed [COORD_W-1:0] right_x;
        logic signed [COORD_W-1:0] right_y;
        logic signed [COORD_W-1:0] left_x;
        logic signed [COORD_W-1:0] left_y;
        logic signed [COORD_W-1:0] top_x;
        logic signed [COORD_W-1:0] top_y;
        logic signed [COORD_W-1:0] bottom_x;
        logic signed [COORD_W-1:0] bottom_y;
        logic        [AREA_W-1:0]  area;
    } t_vertex_set;

    logic i_clk = 1'b0;
    logic i_rst_n;

    evt_in_if  in_if ();
    evt_out_if out_if ();
    evt_cfg_if cfg_if ();

    ellipse_vertex_tracker_top #(
        .TRIG_ITERATIONS(TRIG_STEPS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if),
        .i_cfg  (cfg_if)
    );

    always #1 i_clk = ~i_clk;

    // Tracker state as the testbench believes it to be.
    bit [AXIS_W-1:0] trk_major   = 31'd196608;
    bit [AXIS_W-1:0] trk_minor   = 31'd131072;
    longint          trk_cx      = 0;
    longint          trk_cy      = 0;
    longint          trk_heading = 0;

    longint atan_steps [0:23] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
        64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
        64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
        64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
    };

    t_motion     moves_pending[$];
    t_vertex_set expected_vertices[$];
    t_vertex_set head_set;

    int failures      = 0;
    int items_queued  = 0;
    int results_seen  = 0;
    bit idling_on     = 1'b1;
    bit hold_req      = 1'b0;
    int tx_gap        = 0;
    int rx_gap        = 0;
    int hold_left     = 0;

    function automatic logic signed [COORD_W-1:0] clamp32(input longint v);
        if (v > COORD_MAX) return COORD_MAX[COORD_W-1:0];
        if (v < COORD_MIN) return COORD_MIN[COORD_W-1:0];
        return v[COORD_W-1:0];
    endfunction

    // Axis times a Q30 trig value, rounded half up back to Q16.
    function automatic longint scale_axis(input bit [AXIS_W-1:0] axis, input longint trig);
        longint p;
        p = longint'(axis);
        p = p * trig;
        return (p + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function automatic t_vertex_set advance_ellipse(input logic signed [COORD_W-1:0] sx,
                                                    input logic signed [COORD_W-1:0] sy,
                                                    input logic signed [TURN_W-1:0] tn);
        t_vertex_set r;
        longint h, z, x, y, ddx, ddy, c, s, ax, ay, bx, by;
        bit neg;
        int steps;
        bit [63:0] ab, mid;
        trk_cx = longint'(clamp32(trk_cx + longint'(sx)));
        trk_cy = longint'(clamp32(trk_cy + longint'(sy)));
        h = trk_heading + longint'(tn);
        while (h < 0) h += FULL_TURN_Q16;
        while (h >= FULL_TURN_Q16) h -= FULL_TURN_Q16;
        trk_heading = h;

        // Fold the heading into [-pi/2, pi/2]; a fold by pi flips both signs.
        z = h * 16384;
        neg = 1'b0;
        if (z > QUARTER_TURN_Q30) begin
            if (z < HALF_TURN_Q30 + QUARTER_TURN_Q30) begin
                z -= HALF_TURN_Q30;
                neg = 1'b1;
            end else begin
                z -= 2 * HALF_TURN_Q30;
            end
        end
        x = TRIG_GAIN_Q30;
        y = 0;
        steps = (TRIG_STEPS > 24) ? 24 : TRIG_STEPS;
        for (int i = 0; i < steps; i++) begin
            ddx = y >>> i;
            ddy = x >>> i;
            if (z >= 0) begin
                x -= ddx;
                y += ddy;
                z -= atan_steps[i];
            end else begin
                x += ddx;
                y -= ddy;
                z += atan_steps[i];
            end
        end
        c = neg ? -x : x;
        s = neg ? -y : y;

        ax = scale_axis(trk_major, c);
        ay = scale_axis(trk_major, s);
        bx = scale_axis(trk_minor, s);
        by = scale_axis(trk_minor, c);
        r.right_x  = clamp32(trk_cx + ax);
        r.right_y  = clamp32(trk_cy + ay);
        r.left_x   = clamp32(trk_cx - ax);
        r.left_y   = clamp32(trk_cy - ay);
        r.top_x    = clamp32(trk_cx - bx);
        r.top_y    = clamp32(trk_cy + by);
        r.bottom_x = clamp32(trk_cx + bx);
        r.bottom_y = clamp32(trk_cy - by);

        // The area product is split in two halves to stay within 64 bits.
        ab  = 64'(trk_major) * 64'(trk_minor);
        mid = (ab >> 32) * AREA_PI_Q30 + (((ab & 64'hFFFF_FFFF) * AREA_PI_Q30) >> 32);
        r.area = AREA_W'((mid + 64'd8192) >> 14);
        return r;
    endfunction

    task automatic compare_field(input string label, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, label, $signed(want), $signed(got));
            failures++;
        end
    endtask

    // Input driver: predicts on each accepted transfer and offers the next move.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (tx_gap > 0) begin
                tx_gap--;
            end else if (idling_on && $urandom_range(0, 15) == 0) begin
                tx_gap = $urandom_range(1, 17);
            end
            if (in_if.valid && in_if.ready) begin
                expected_vertices.push_back(
                    advance_ellipse(in_if.shift_x, in_if.shift_y, in_if.turn));
            end
            if (!in_if.valid || in_if.ready) begin
                if (tx_gap == 0 && moves_pending.size() != 0) begin
                    t_motion m;
                    m = moves_pending.pop_front();
                    in_if.shift_x <= m.shift_x;
                    in_if.shift_y <= m.shift_y;
                    in_if.turn    <= m.turn;
                    in_if.valid   <= 1'b1;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: checks each transfer and throttles ready.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                results_seen++;
                if (expected_vertices.size() == 0) begin
                    $display("%0t ns: result transfer with nothing expected", $time);
                    failures++;
                end else begin
                    head_set = expected_vertices.pop_front();
                    compare_field("right_x",  64'(head_set.right_x),  64'(out_if.right_x));
                    compare_field("right_y",  64'(head_set.right_y),  64'(out_if.right_y));
                    compare_field("left_x",   64'(head_set.left_x),   64'(out_if.left_x));
                    compare_field("left_y",   64'(head_set.left_y),   64'(out_if.left_y));
                    compare_field("top_x",    64'(head_set.top_x),    64'(out_if.top_x));
                    compare_field("top_y",    64'(head_set.top_y),    64'(out_if.top_y));
                    compare_field("bottom_x", 64'(head_set.bottom_x), 64'(out_if.bottom_x));
                    compare_field("bottom_y", 64'(head_set.bottom_y), 64'(out_if.bottom_y));
                    compare_field("area_out", 64'(head_set.area),     64'(out_if.area_out));
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = LONG_HOLD - 1;
                out_if.ready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                out_if.ready <= 1'b0;
            end else if (idling_on && $urandom_range(0, 7) == 0) begin
                rx_gap = $urandom_range(1, 17) - 1;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        cfg_if.valid <= 1'b1;
        do @(posedge i_clk); while (!cfg_if.ready);
        if (idx == CFG_SEMI_MAJOR) begin
            trk_major = val[AXIS_W-1:0];
        end else if (idx == CFG_SEMI_MINOR) begin
            trk_minor = val[AXIS_W-1:0];
        end
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic queue_move(input logic signed [COORD_W-1:0] sx,
                              input logic signed [COORD_W-1:0] sy,
                              input logic signed [TURN_W-1:0] tn);
        t_motion m;
        m.shift_x = sx;
        m.shift_y = sy;
        m.turn    = tn;
        moves_pending.push_back(m);
        items_queued++;
    endtask

    task automatic wait_drained();
        while (results_seen < items_queued) @(posedge i_clk);
    endtask

    function automatic logic signed [COORD_W-1:0] rand_shift();
        case ($urandom_range(0, 19))
            0, 1:    return $urandom;
            2:       return $urandom_range(0, 1) ? SHIFT_MAX : SHIFT_MIN;
            default: return int'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
        endcase
    endfunction

    function automatic logic signed [TURN_W-1:0] rand_turn();
        case ($urandom_range(0, 9))
            0: return TURN_W'(int'($urandom_range(0, 2000)) - 1000);
            1: return $urandom_range(0, 1) ? TURN_MAX : TURN_MIN;
            2: return $urandom_range(0, 1) ? 20'sd411775 : -20'sd411775;
            default: return TURN_W'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] rand_axis();
        case ($urandom_range(0, 5))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2, 3:    return $urandom_range(0, 32'h0040_0000);
            4:       return $urandom_range(0, 32'h0400_0000);
            default: return $urandom;
        endcase
    endfunction

    initial begin : sequencer
        i_rst_n       = 1'b0;
        in_if.valid   = 1'b0;
        in_if.shift_x = '0;
        in_if.shift_y = '0;
        in_if.turn    = '0;
        out_if.ready  = 1'b0;
        cfg_if.valid  = 1'b0;
        cfg_if.index  = CFG_SEMI_MAJOR;
        cfg_if.data   = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset axes: walk the heading across both fold boundaries and the wrap,
        // then drive the centre into both saturation rails.
        queue_move(0, 0, 0);
        queue_move(32'sh0001_0000, -32'sh0001_0000, 20'sd102943);
        queue_move(0, 0, 1);
        queue_move(0, 0, 20'sd205887);
        queue_move(0, 0, 1);
        queue_move(0, 0, 20'sd102942);
        queue_move(0, 0, 1);
        queue_move(0, 0, TURN_MAX);
        queue_move(0, 0, TURN_MIN);
        queue_move(0, 0, 20'sd411775);
        queue_move(0, 0, -20'sd411775);
        queue_move(SHIFT_MAX, SHIFT_MAX, 0);
        queue_move(SHIFT_MAX, 0, 0);
        queue_move(SHIFT_MIN, SHIFT_MIN, 0);
        queue_move(SHIFT_MIN, SHIFT_MIN, 0);
        queue_move(SHIFT_MIN, SHIFT_MIN, 20'sd102944);
        wait_drained();

        // Largest axes, with the top data bit set so that masking is seen,
        // and writes to the unused indexes that must change nothing.
        write_reg(CFG_SEMI_MAJOR, 32'hFFFF_FFFF);
        write_reg(CFG_SEMI_MINOR, 32'h7FFF_FFFF);
        write_reg(CFG_SPARE_2, 32'h0000_0001);
        write_reg(CFG_SPARE_3, 32'hFFFF_FFFF);
        queue_move(0, 0, 0);
        queue_move(SHIFT_MAX, SHIFT_MAX, 0);
        queue_move(SHIFT_MAX, SHIFT_MAX, 20'sd102944);
        queue_move(0, 0, 20'sd205887);
        wait_drained();

        write_reg(CFG_SEMI_MINOR, 32'h0000_0000);
        write_reg(CFG_SEMI_MAJOR, 32'h8000_0000);
        queue_move(SHIFT_MIN, SHIFT_MAX, -1);
        queue_move(0, 0, 0);
        queue_move(1, -1, TURN_MAX);
        wait_drained();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            if ($urandom_range(0, 1)) begin
                write_reg(CFG_SEMI_MAJOR, rand_axis());
                write_reg(CFG_SEMI_MINOR, rand_axis());
            end else begin
                write_reg(CFG_SEMI_MINOR, rand_axis());
                write_reg(CFG_SEMI_MAJOR, rand_axis());
            end
            if ($urandom_range(0, 2) == 0) begin
                write_reg($urandom_range(0, 1) ? CFG_SPARE_2 : CFG_SPARE_3, $urandom);
            end
            // The last phase runs flat out on both sides.
            idling_on = (ph != RANDOM_PHASES - 1);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                queue_move(rand_shift(), rand_shift(), rand_turn());
            end
            if (ph == HOLD_PHASE) begin
                hold_req = 1'b1;
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_vertices.size() != 0) begin
            $display("%0t ns: %0d expected results never arrived",
                     $time, expected_vertices.size());
            failures++;
        end
        if (failures == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin : watchdog
        #1_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
